>>> src/ksm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ksm_pkg
// Shared sizes, command codes and sequencer types for the two-list median
// selection block.
// ----------------------------------------------------------------------------
package ksm_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  // rank and index arithmetic spans both lists
  localparam int K_W    = CNT_W + 1;
  localparam int DATA_W = 32;
  localparam int SUM_W  = 33;

  typedef enum logic [1:0] {
    CMD_PUSH_A = 2'd0,
    CMD_PUSH_B = 2'd1,
    CMD_MEDIAN = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_EVAL
  } state_t;

  // what the registered reads are used for in the eval cycle
  typedef enum logic [1:0] {
    M_CMP,
    M_FIN_A,
    M_FIN_B,
    M_FIN_MIN
  } mode_t;

endpackage
`default_nettype wire

>>> src/kth_select_median_two_sorted.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kth_select_median_two_sorted
// Two list stores with a halving k-th selection sequencer; returns twice
// the median of the merged lists.
// ----------------------------------------------------------------------------
// Usage:
//   An item (cmd, value) transfers on a rising edge with start high and
//   busy low. cmd 0 / 1 append value to the first / second list without
//   raising busy, so pushes can follow back to back; a push to a full list is
//   dropped and sets the sticky overflow flag. cmd 3 is ignored.
//   cmd 2 raises busy and runs two k-th selections (lower and upper middle
//   rank). A halving step stays in the step state when a probe lies past
//   the end of a list, else it is a registered read of both stores and then
//   one signed compare; the last step of each selection is a read plus eval.
//   Compute time is bounded by the one read port per store and the single
//   comparator; with both lists empty the result comes in the cycle after
//   the transfer.
//   The result (median_twice, both_empty, overflow) is shown for one cycle
//   with done high; the receiver cannot stall it. Counts and the flag are
//   cleared with the result, and busy is low in the done cycle.
//   Reset clears counts, flag and sequencer; store contents are left as is.
// ----------------------------------------------------------------------------
module kth_select_median_two_sorted
  import ksm_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [1:0]               cmd,
  input  wire logic signed [DATA_W-1:0] value,
  output logic                          done,
  output logic signed [SUM_W-1:0]       median_twice,
  output logic                          both_empty,
  output logic                          overflow
);

  logic signed [DATA_W-1:0] first_mem  [DEPTH];
  logic signed [DATA_W-1:0] second_mem [DEPTH];

  state_t state, state_next;
  mode_t  mode, mode_next;
  logic [CNT_W-1:0] first_count, first_count_next;
  logic [CNT_W-1:0] second_count, second_count_next;
  logic             dropped, dropped_next;
  logic [K_W-1:0]   i, i_next, j, j_next, k, k_next, h, h_next;
  logic [K_W-1:0]   total;
  logic             pass, pass_next;
  logic signed [SUM_W-1:0] acc, acc_next;
  logic signed [SUM_W-1:0] median_twice_next;
  logic             done_next, both_empty_next, overflow_next;

  logic signed [DATA_W-1:0] rd_a, rd_b, res;
  logic             rd_en;
  logic [ADDR_W-1:0] addr_a, addr_b;
  logic             push_a, push_b;

  logic [K_W-1:0] m_ext, n_ext, half, pa, pb, idx_a, idx_b, clamp_a, clamp_b;
  logic [K_W:0]   rank_lo, rank_hi;
  logic           a_inf, b_inf, take_first;

  assign busy  = (state != S_IDLE);
  assign m_ext = {1'b0, first_count};
  assign n_ext = {1'b0, second_count};
  assign total = m_ext + n_ext;
  assign rank_lo = ({1'b0, total} + {{K_W{1'b0}}, 1'b1}) >> 1;
  assign rank_hi = ({1'b0, total} + {{(K_W-1){1'b0}}, 2'd2}) >> 1;

  assign half  = k >> 1;
  assign pa    = i + half - {{(K_W-1){1'b0}}, 1'b1};
  assign pb    = j + half - {{(K_W-1){1'b0}}, 1'b1};
  assign a_inf = (pa >= m_ext);
  assign b_inf = (pb >= n_ext);
  // final reads clamp into the valid part of the list
  assign idx_a   = i + k - {{(K_W-1){1'b0}}, 1'b1};
  assign idx_b   = j + k - {{(K_W-1){1'b0}}, 1'b1};
  assign clamp_a = (idx_a >= m_ext) ? (m_ext - {{(K_W-1){1'b0}}, 1'b1}) : idx_a;
  assign clamp_b = (idx_b >= n_ext) ? (n_ext - {{(K_W-1){1'b0}}, 1'b1}) : idx_b;

  assign take_first = (rd_a < rd_b);

  always_comb begin
    state_next        = state;
    mode_next         = mode;
    first_count_next  = first_count;
    second_count_next = second_count;
    dropped_next      = dropped;
    i_next            = i;
    j_next            = j;
    k_next            = k;
    h_next            = h;
    pass_next         = pass;
    acc_next          = acc;
    done_next         = 1'b0;
    median_twice_next = median_twice;
    both_empty_next   = both_empty;
    overflow_next     = overflow;
    rd_en             = 1'b0;
    addr_a            = i[ADDR_W-1:0];
    addr_b            = j[ADDR_W-1:0];
    push_a            = 1'b0;
    push_b            = 1'b0;
    res               = rd_a;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (cmd_t'(cmd))
            CMD_PUSH_A: begin
              if (m_ext < K_W'(DEPTH)) begin
                push_a           = 1'b1;
                first_count_next = first_count + CNT_W'(1);
              end else begin
                dropped_next = 1'b1;
              end
            end
            CMD_PUSH_B: begin
              if (n_ext < K_W'(DEPTH)) begin
                push_b            = 1'b1;
                second_count_next = second_count + CNT_W'(1);
              end else begin
                dropped_next = 1'b1;
              end
            end
            CMD_MEDIAN: begin
              if (total == '0) begin
                done_next         = 1'b1;
                median_twice_next = '0;
                both_empty_next   = 1'b1;
                overflow_next     = dropped;
                dropped_next      = 1'b0;
              end else begin
                i_next     = '0;
                j_next     = '0;
                k_next     = rank_lo[K_W-1:0];
                pass_next  = 1'b0;
                acc_next   = '0;
                state_next = S_STEP;
              end
            end
            default: ;
          endcase
        end
      end

      S_STEP: begin
        if (i >= m_ext) begin
          addr_b     = clamp_b[ADDR_W-1:0];
          rd_en      = 1'b1;
          mode_next  = M_FIN_B;
          state_next = S_EVAL;
        end else if (j >= n_ext) begin
          addr_a     = clamp_a[ADDR_W-1:0];
          rd_en      = 1'b1;
          mode_next  = M_FIN_A;
          state_next = S_EVAL;
        end else if (k == K_W'(1)) begin
          rd_en      = 1'b1;
          mode_next  = M_FIN_MIN;
          state_next = S_EVAL;
        end else if (a_inf) begin
          j_next = j + half;
          k_next = k - half;
        end else if (b_inf) begin
          i_next = i + half;
          k_next = k - half;
        end else begin
          addr_a     = pa[ADDR_W-1:0];
          addr_b     = pb[ADDR_W-1:0];
          rd_en      = 1'b1;
          h_next     = half;
          mode_next  = M_CMP;
          state_next = S_EVAL;
        end
      end

      S_EVAL: begin
        if (mode == M_CMP) begin
          if (take_first) begin
            i_next = i + h;
          end else begin
            j_next = j + h;
          end
          k_next     = k - h;
          state_next = S_STEP;
        end else begin
          unique case (mode)
            M_FIN_B:   res = rd_b;
            M_FIN_MIN: res = take_first ? rd_a : rd_b;
            default:   res = rd_a;
          endcase
          if (!pass) begin
            acc_next   = SUM_W'(res);
            pass_next  = 1'b1;
            i_next     = '0;
            j_next     = '0;
            k_next     = rank_hi[K_W-1:0];
            state_next = S_STEP;
          end else begin
            done_next         = 1'b1;
            median_twice_next = acc + SUM_W'(res);
            both_empty_next   = 1'b0;
            overflow_next     = dropped;
            dropped_next      = 1'b0;
            first_count_next  = '0;
            second_count_next = '0;
            state_next        = S_IDLE;
          end
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      first_count  <= '0;
      second_count <= '0;
      dropped      <= 1'b0;
      done         <= 1'b0;
    end else begin
      state        <= state_next;
      first_count  <= first_count_next;
      second_count <= second_count_next;
      dropped      <= dropped_next;
      done         <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    mode         <= mode_next;
    i            <= i_next;
    j            <= j_next;
    k            <= k_next;
    h            <= h_next;
    pass         <= pass_next;
    acc          <= acc_next;
    median_twice <= median_twice_next;
    both_empty   <= both_empty_next;
    overflow     <= overflow_next;
  end

  // stores: one write and one registered read each
  always_ff @(posedge clk) begin
    if (push_a) begin
      first_mem[first_count[ADDR_W-1:0]] <= value;
    end
    if (rd_en) begin
      rd_a <= first_mem[addr_a];
    end
  end

  always_ff @(posedge clk) begin
    if (push_b) begin
      second_mem[second_count[ADDR_W-1:0]] <= value;
    end
    if (rd_en) begin
      rd_b <= second_mem[addr_b];
    end
  end

  // result only after a compute transfer or at the end of a selection run
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || (start && cmd == CMD_MEDIAN)))
    else $error("result strobe without a compute");

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && first_count == '0 && second_count == '0 && !dropped))
    else $error("state not cleared with result");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (m_ext <= K_W'(DEPTH)) && (n_ext <= K_W'(DEPTH)))
    else $error("list count past depth");

  a_counts_hold: assert property (@(posedge clk) disable iff (rst)
    (busy && state_next != S_IDLE) |=> ($stable(first_count) && $stable(second_count)))
    else $error("count changed during selection");

endmodule
`default_nettype wire
